// ----- hw/rtl/tip_pkg.sv -----
// ----------------------------------------------------------------------------
// tip_pkg: shared types and constants for the turn-in-place position hold
// Configuration map, queue item format and fixed-point helpers.
// ----------------------------------------------------------------------------
package tip_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 19;

    localparam logic [CfgIdxW-1:0] CFG_HOLD_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_GAIN   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SPEED_LIMIT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PLANAR_DB   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_YAW_DB      = 3'd4;

    localparam logic [1:0] ST_CLEARED    = 2'd0;
    localparam logic [1:0] ST_CAPTURED   = 2'd1;
    localparam logic [1:0] ST_CORRECTING = 2'd2;

    localparam logic signed [19:0] HalfPi = 20'sd102944;
    localparam logic signed [19:0] Pi     = 20'sd205887;
    localparam logic signed [32:0] CordicK = 33'sd652032874;
    localparam logic [4:0] CordicLast = 5'd16;

    typedef struct packed {
        logic        en;
        logic [15:0] gain;
        logic [18:0] lim;
        logic [15:0] pdb;
        logic [15:0] ydb;
    } t_cfg;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [18:0] yaw;
        logic signed [19:0] bx;
        logic signed [19:0] by;
    } t_item;

    function automatic logic [15:0] atan_lut(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:  r = 16'd51472;
            5'd1:  r = 16'd30386;
            5'd2:  r = 16'd16055;
            5'd3:  r = 16'd8150;
            5'd4:  r = 16'd4091;
            5'd5:  r = 16'd2047;
            5'd6:  r = 16'd1024;
            5'd7:  r = 16'd512;
            5'd8:  r = 16'd256;
            5'd9:  r = 16'd128;
            5'd10: r = 16'd64;
            5'd11: r = 16'd32;
            5'd12: r = 16'd16;
            5'd13: r = 16'd8;
            5'd14: r = 16'd4;
            5'd15: r = 16'd2;
            5'd16: r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [36:0] v);
        logic signed [19:0] r;
        if (v > 37'sd524287) begin
            r = 20'sd524287;
        end else if (v < -37'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/turn_in_place_position_hold_top.sv -----
// ----------------------------------------------------------------------------
// turn_in_place_position_hold_top: position hold during in-place turns
// Request channel in, result channel out, register write port.
//
// Requests enter on i_in_valid/o_in_stall; one result per request leaves on
// o_out_valid/i_out_stall, in request order. Registers are written through
// i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; o_cfg_ready is
// always high. Write registers only while no request is in flight.
// The front takes a request and pushes it into a two-entry queue, stalling
// new requests until the push. The back sequencer sets the rate: a cleared
// or capture request goes straight to output; a correcting request runs 17
// CORDIC steps, shared multiplier passes and normalize shifts while a magnitude
// tops 2^30, plus, when the speed clamp runs, 32-step root and 19-step divide lanes.
// Synchronous active-low reset clears the anchor, loads register defaults
// and empties queue and output. While the receiver stalls, the result is
// held, the back waits, and the front stalls once the queue is full.
// ----------------------------------------------------------------------------
module turn_in_place_position_hold_top
    import tip_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_walk_mode,
    input  logic                i_bus_ok,
    input  logic                i_measurements_valid,
    input  logic signed [19:0]  i_cmd_vx,
    input  logic signed [19:0]  i_cmd_vy,
    input  logic signed [19:0]  i_cmd_yaw_rate,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [18:0]  i_yaw,
    input  logic signed [19:0]  i_base_x,
    input  logic signed [19:0]  i_base_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_hold_status,
    output logic signed [19:0]  o_correction_x,
    output logic signed [19:0]  o_correction_y,
    output logic signed [19:0]  o_out_x,
    output logic signed [19:0]  o_out_y,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_item q_wdata;
    t_item q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en   <= 1'b1;
            r_cfg.gain <= 16'd13107;
            r_cfg.lim  <= 19'd1966;
            r_cfg.pdb  <= 16'd0;
            r_cfg.ydb  <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HOLD_ENABLE: r_cfg.en   <= i_cfg_data[0];
                CFG_HOLD_GAIN:   r_cfg.gain <= i_cfg_data[15:0];
                CFG_SPEED_LIMIT: r_cfg.lim  <= i_cfg_data;
                CFG_PLANAR_DB:   r_cfg.pdb  <= i_cfg_data[15:0];
                CFG_YAW_DB:      r_cfg.ydb  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    tip_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_walk_mode          (i_walk_mode),
        .i_bus_ok             (i_bus_ok),
        .i_measurements_valid (i_measurements_valid),
        .i_cmd_vx             (i_cmd_vx),
        .i_cmd_vy             (i_cmd_vy),
        .i_cmd_yaw_rate       (i_cmd_yaw_rate),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_yaw                (i_yaw),
        .i_base_x             (i_base_x),
        .i_base_y             (i_base_y),
        .i_q_full             (q_full),
        .o_q_push             (q_push),
        .o_q_data             (q_wdata)
    );

    tip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    tip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (q_empty),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hold_status  (o_hold_status),
        .o_correction_x (o_correction_x),
        .o_correction_y (o_correction_y),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y)
    );

endmodule

// ----- hw/rtl/tip_queue.sv -----
// ----------------------------------------------------------------------------
// tip_queue: two-entry request queue
// Decouples the classifying front from the arithmetic back.
// ----------------------------------------------------------------------------
module tip_queue
    import tip_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/tip_front.sv -----
// ----------------------------------------------------------------------------
// tip_front: request intake and classification
// Takes a request, checks flags and deadbands, queues it with a hold flag.
// ----------------------------------------------------------------------------
module tip_front
    import tip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_walk_mode,
    input  logic               i_bus_ok,
    input  logic               i_measurements_valid,
    input  logic signed [19:0] i_cmd_vx,
    input  logic signed [19:0] i_cmd_vy,
    input  logic signed [19:0] i_cmd_yaw_rate,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [18:0] i_yaw,
    input  logic signed [19:0] i_base_x,
    input  logic signed [19:0] i_base_y,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_item              o_q_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQR  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state;
    logic               r_flags;
    logic signed [19:0] r_vx;
    logic signed [19:0] r_vy;
    logic signed [19:0] r_yr;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [18:0] r_yaw;
    logic signed [19:0] r_bx;
    logic signed [19:0] r_by;
    logic [39:0]        r_sqx;
    logic [39:0]        r_sqy;
    logic [31:0]        r_pd2;
    logic [19:0]        yr_mag;
    logic [40:0]        p2;
    logic               ok;

    assign o_in_stall = (r_state != F_IDLE);
    assign yr_mag     = r_yr[19] ? 20'(-r_yr) : 20'(r_yr);
    assign p2         = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign ok         = r_flags && (p2 <= {9'd0, r_pd2}) && (yr_mag > {4'd0, i_cfg.ydb});
    assign o_q_push   = (r_state == F_PUSH) && !i_q_full;

    always_comb begin
        o_q_data     = '0;
        o_q_data.ok  = ok;
        o_q_data.px  = r_px;
        o_q_data.py  = r_py;
        o_q_data.yaw = r_yaw;
        o_q_data.bx  = r_bx;
        o_q_data.by  = r_by;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_flags <= i_cfg.en & i_walk_mode & i_bus_ok & i_measurements_valid;
            r_vx    <= i_cmd_vx;
            r_vy    <= i_cmd_vy;
            r_yr    <= i_cmd_yaw_rate;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_yaw   <= i_yaw;
            r_bx    <= i_base_x;
            r_by    <= i_base_y;
        end
        if (r_state == F_SQR) begin
            r_sqx <= 40'(r_vx * r_vx);
            r_sqy <= 40'(r_vy * r_vy);
            r_pd2 <= i_cfg.pdb * i_cfg.pdb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= F_SQR;
                    end
                end
                F_SQR: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/tip_back.sv -----
// ----------------------------------------------------------------------------
// tip_back: anchor tracking and correction sequencer
// CORDIC rotation, shared multiplier, root and divide lanes, result register.
// ----------------------------------------------------------------------------
module tip_back
    import tip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_item              i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_hold_status,
    output logic signed [19:0] o_correction_x,
    output logic signed [19:0] o_correction_y,
    output logic signed [19:0] o_out_x,
    output logic signed [19:0] o_out_y
);

    typedef enum logic [22:0] {
        B_IDLE = 23'h000001,
        B_ROT  = 23'h000002,
        B_CS   = 23'h000004,
        B_M0   = 23'h000008,
        B_M1   = 23'h000010,
        B_M2   = 23'h000020,
        B_M3   = 23'h000040,
        B_M4   = 23'h000080,
        B_G0   = 23'h000100,
        B_G1   = 23'h000200,
        B_G2   = 23'h000400,
        B_NORM = 23'h000800,
        B_SQ0  = 23'h001000,
        B_SQ1  = 23'h002000,
        B_SQ2  = 23'h004000,
        B_CMP  = 23'h008000,
        B_SQRT = 23'h010000,
        B_D0   = 23'h020000,
        B_D1   = 23'h040000,
        B_D2   = 23'h080000,
        B_DIV  = 23'h100000,
        B_FIN  = 23'h200000,
        B_OUT  = 23'h400000
    } t_bstate;

    t_bstate            r_state;
    logic               r_anc_valid;
    logic signed [31:0] r_anc_x;
    logic signed [31:0] r_anc_y;
    logic signed [19:0] r_bx;
    logic signed [19:0] r_by;
    logic [1:0]         r_status;
    logic signed [19:0] r_cx;
    logic signed [19:0] r_cy;
    logic signed [33:0] r_dx;
    logic signed [33:0] r_dy;
    logic               r_neg;
    logic signed [19:0] r_z;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic [4:0]         r_i;
    logic signed [30:0] r_c;
    logic signed [30:0] r_s;
    logic signed [67:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [35:0] r_ex;
    logic signed [35:0] r_ey;
    logic signed [36:0] r_vx;
    logic signed [36:0] r_vy;
    logic               r_negx;
    logic               r_negy;
    logic [36:0]        r_ax;
    logic [36:0]        r_ay;
    logic               r_big;
    logic [63:0]        r_sum;
    logic [63:0]        r_sv;
    logic [63:0]        r_sr;
    logic [63:0]        r_sb;
    logic [31:0]        r_remx;
    logic [31:0]        r_remy;
    logic [18:0]        r_dlx;
    logic [18:0]        r_dly;
    logic [18:0]        r_qx;
    logic [18:0]        r_qy;

    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] neg_prod;
    logic signed [36:0] v_new;
    logic signed [19:0] yaw_w;
    logic signed [32:0] x_sh;
    logic signed [32:0] y_sh;
    logic signed [19:0] at_w;
    logic signed [32:0] xf;
    logic signed [32:0] yf;
    logic [63:0]        sq_try;
    logic [32:0]        remx2;
    logic [32:0]        remy2;
    logic [32:0]        sp;
    logic               out_free;
    logic signed [20:0] sum_x;
    logic signed [20:0] sum_y;

    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign out_free = !o_out_valid || !i_out_stall;
    assign neg_prod = -r_prod[63:0];
    assign v_new    = neg_prod[52:16];
    assign yaw_w    = 20'(i_q_data.yaw);
    assign x_sh     = r_x >>> r_i;
    assign y_sh     = r_y >>> r_i;
    assign at_w     = 20'(atan_lut(r_i));
    assign xf       = r_neg ? -r_x : r_x;
    assign yf       = r_neg ? -r_y : r_y;
    assign sq_try   = r_sr + r_sb;
    assign sp       = {1'b0, r_sr[31:0]};
    assign remx2    = {r_remx, r_dlx[18]};
    assign remy2    = {r_remy, r_dly[18]};
    assign sum_x    = 21'(r_bx) + 21'(r_cx);
    assign sum_y    = 21'(r_by) + 21'(r_cy);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            B_M0: begin
                mul_a = 36'(r_dx);
                mul_b = 32'(r_c);
            end
            B_M1: begin
                mul_a = 36'(r_dy);
                mul_b = 32'(r_s);
            end
            B_M2: begin
                mul_a = 36'(r_dy);
                mul_b = 32'(r_c);
            end
            B_M3: begin
                mul_a = 36'(r_dx);
                mul_b = 32'(r_s);
            end
            B_G0: begin
                mul_a = r_ex;
                mul_b = {16'd0, i_cfg.gain};
            end
            B_G1: begin
                mul_a = r_ey;
                mul_b = {16'd0, i_cfg.gain};
            end
            B_SQ0: begin
                mul_a = {5'd0, r_ax[30:0]};
                mul_b = {1'b0, r_ax[30:0]};
            end
            B_SQ1: begin
                mul_a = {5'd0, r_ay[30:0]};
                mul_b = {1'b0, r_ay[30:0]};
            end
            B_SQ2: begin
                mul_a = {17'd0, i_cfg.lim};
                mul_b = {13'd0, i_cfg.lim};
            end
            B_D0: begin
                mul_a = {5'd0, r_ax[30:0]};
                mul_b = {13'd0, i_cfg.lim};
            end
            B_D1: begin
                mul_a = {5'd0, r_ay[30:0]};
                mul_b = {13'd0, i_cfg.lim};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_bx <= i_q_data.bx;
                r_by <= i_q_data.by;
                r_cx <= '0;
                r_cy <= '0;
                r_dx <= 34'(i_q_data.px) - 34'(r_anc_x);
                r_dy <= 34'(i_q_data.py) - 34'(r_anc_y);
                r_x  <= CordicK;
                r_y  <= '0;
                r_i  <= '0;
                if (yaw_w > HalfPi) begin
                    r_z   <= yaw_w - Pi;
                    r_neg <= 1'b1;
                end else if (yaw_w < -HalfPi) begin
                    r_z   <= yaw_w + Pi;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= yaw_w;
                    r_neg <= 1'b0;
                end
            end
            B_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x - y_sh;
                    r_y <= r_y + x_sh;
                    r_z <= r_z - at_w;
                end else begin
                    r_x <= r_x + y_sh;
                    r_y <= r_y - x_sh;
                    r_z <= r_z + at_w;
                end
                r_i <= r_i + 5'd1;
            end
            B_CS: begin
                r_c <= 31'(xf >>> 2);
                r_s <= 31'(yf >>> 2);
            end
            B_M1: r_acc <= r_prod[63:0];
            B_M2: r_ex <= 36'((r_acc + r_prod[63:0]) >>> 28);
            B_M3: r_acc <= r_prod[63:0];
            B_M4: r_ey <= 36'((r_acc - r_prod[63:0]) >>> 28);
            B_G1: r_vx <= v_new;
            B_G2: begin
                r_vy   <= v_new;
                r_negx <= r_vx[36];
                r_negy <= v_new[36];
                r_ax   <= r_vx[36] ? 37'(-r_vx) : 37'(r_vx);
                r_ay   <= v_new[36] ? 37'(-v_new) : 37'(v_new);
                r_big  <= 1'b0;
            end
            B_NORM: begin
                if (r_ax > 37'd1073741824 || r_ay > 37'd1073741824) begin
                    r_ax  <= r_ax >> 1;
                    r_ay  <= r_ay >> 1;
                    r_big <= 1'b1;
                end
            end
            B_SQ1: r_acc <= r_prod[63:0];
            B_SQ2: r_sum <= 64'(r_acc + r_prod[63:0]);
            B_CMP: begin
                r_sv <= r_sum;
                r_sr <= '0;
                r_sb <= 64'd1 << 62;
            end
            B_SQRT: begin
                if (r_sv >= sq_try) begin
                    r_sv <= r_sv - sq_try;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            B_D1: begin
                r_remx <= {1'b0, r_prod[49:19]};
                r_dlx  <= r_prod[18:0];
            end
            B_D2: begin
                r_remy <= {1'b0, r_prod[49:19]};
                r_dly  <= r_prod[18:0];
                r_i    <= '0;
            end
            B_DIV: begin
                if (remx2 >= sp) begin
                    r_remx <= 32'(remx2 - sp);
                    r_qx   <= {r_qx[17:0], 1'b1};
                end else begin
                    r_remx <= remx2[31:0];
                    r_qx   <= {r_qx[17:0], 1'b0};
                end
                if (remy2 >= sp) begin
                    r_remy <= 32'(remy2 - sp);
                    r_qy   <= {r_qy[17:0], 1'b1};
                end else begin
                    r_remy <= remy2[31:0];
                    r_qy   <= {r_qy[17:0], 1'b0};
                end
                r_dlx <= r_dlx << 1;
                r_dly <= r_dly << 1;
                r_i   <= r_i + 5'd1;
                if (r_i == 5'd18) begin
                    r_vx <= r_negx ? -37'({1'b0, r_qx[17:0], remx2 >= sp})
                                   : 37'({1'b0, r_qx[17:0], remx2 >= sp});
                    r_vy <= r_negy ? -37'({1'b0, r_qy[17:0], remy2 >= sp})
                                   : 37'({1'b0, r_qy[17:0], remy2 >= sp});
                end
            end
            B_FIN: begin
                r_cx <= sat20(r_vx);
                r_cy <= sat20(r_vy);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_OUT && out_free) begin
            o_hold_status  <= r_status;
            o_correction_x <= r_cx;
            o_correction_y <= r_cy;
            o_out_x        <= sat20(37'(sum_x));
            o_out_y        <= sat20(37'(sum_y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_anc_valid <= 1'b0;
            r_anc_x     <= '0;
            r_anc_y     <= '0;
            r_status    <= ST_CLEARED;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == B_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        if (!i_q_data.ok) begin
                            r_anc_valid <= 1'b0;
                            r_anc_x     <= '0;
                            r_anc_y     <= '0;
                            r_status    <= ST_CLEARED;
                            r_state     <= B_OUT;
                        end else if (!r_anc_valid) begin
                            r_anc_valid <= 1'b1;
                            r_anc_x     <= i_q_data.px;
                            r_anc_y     <= i_q_data.py;
                            r_status    <= ST_CAPTURED;
                            r_state     <= B_OUT;
                        end else begin
                            r_status <= ST_CORRECTING;
                            r_state  <= B_ROT;
                        end
                    end
                end
                B_ROT: begin
                    if (r_i == CordicLast) begin
                        r_state <= B_CS;
                    end
                end
                B_CS:   r_state <= B_M0;
                B_M0:   r_state <= B_M1;
                B_M1:   r_state <= B_M2;
                B_M2:   r_state <= B_M3;
                B_M3:   r_state <= B_M4;
                B_M4:   r_state <= B_G0;
                B_G0:   r_state <= B_G1;
                B_G1:   r_state <= B_G2;
                B_G2:   r_state <= B_NORM;
                B_NORM: begin
                    if (!(r_ax > 37'd1073741824 || r_ay > 37'd1073741824)) begin
                        r_state <= B_SQ0;
                    end
                end
                B_SQ0:  r_state <= B_SQ1;
                B_SQ1:  r_state <= B_SQ2;
                B_SQ2:  r_state <= B_CMP;
                B_CMP: begin
                    if (r_big || r_sum > 64'(r_prod[37:0])) begin
                        r_state <= B_SQRT;
                    end else begin
                        r_state <= B_FIN;
                    end
                end
                B_SQRT: begin
                    if (r_sb == 64'd1) begin
                        r_state <= B_D0;
                    end
                end
                B_D0:   r_state <= B_D1;
                B_D1:   r_state <= B_D2;
                B_D2:   r_state <= B_DIV;
                B_DIV: begin
                    if (r_i == 5'd18) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN:  r_state <= B_OUT;
                B_OUT: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule
